// ===== src/mg3_pkg.sv =====
// shared constants, types and helpers for the 3x3 morphological gradient
package mg3_pkg;

   localparam int PIX_W        = 8;
   localparam int LINE_DEPTH   = 256;
   localparam int COL_W        = $clog2(LINE_DEPTH);
   localparam int ROW_W        = 10;
   localparam int WIDTH_REG_W  = 9;
   localparam int HEIGHT_REG_W = 10;
   localparam int CSR_DATA_W   = 10;
   localparam int RSP_DATA_W   = 32;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 9'd160;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_MIN    = 9'd3;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_MAX    = WIDTH_REG_W'(LINE_DEPTH);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 10'd120;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN   = 10'd3;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // position of one pixel in the frame, as seen when it is taken in
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
      logic             interior;
   } pos_type;

   function automatic pixel_type pix_max(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type pix_min(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ===== src/mg3_position.sv =====
// column and row tracker with frame wrap and start-of-frame restart
module mg3_position import mg3_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    sof,
   input  logic [WIDTH_REG_W-1:0]  image_width,
   input  logic [HEIGHT_REG_W-1:0] image_height,
   output pos_type                 pos
);

   logic [COL_W-1:0]        col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]        row_pos_ff, row_pos_in;
   logic [WIDTH_REG_W-1:0]  w;
   logic [HEIGHT_REG_W-1:0] h;
   logic [COL_W-1:0]        col_s, col_c;
   logic [ROW_W-1:0]        row_s, row_c;
   logic [WIDTH_REG_W-1:0]  col_next;
   logic [ROW_W:0]          row_next;

   always_comb begin
      // clamp the registers into the usable range
      w = image_width;
      if (w < WIDTH_MIN) w = WIDTH_MIN;
      if (w > WIDTH_MAX) w = WIDTH_MAX;
      h = image_height;
      if (h < HEIGHT_MIN) h = HEIGHT_MIN;

      col_s = sof ? '0 : col_pos_ff;
      row_s = sof ? '0 : row_pos_ff;

      // position may lie beyond a freshly shrunk width or height
      col_c = col_s;
      row_c = row_s;
      if ({1'b0, col_s} >= w) begin
         col_c = '0;
         row_c = row_s + 1'b1;
      end
      if (row_c >= h) row_c = '0;

      col_next = {1'b0, col_c} + 1'b1;
      row_next = {1'b0, row_c} + 1'b1;
      if (col_next >= w) begin
         col_pos_in = '0;
         row_pos_in = (row_next >= {1'b0, h}) ? '0 : row_next[ROW_W-1:0];
      end else begin
         col_pos_in = col_next[COL_W-1:0];
         row_pos_in = row_c;
      end

      pos.col      = col_c;
      pos.row      = row_c;
      pos.last     = ({1'b0, col_c} == w - 1'b1) && (row_c == h - 1'b1);
      pos.interior = (col_c >= COL_W'(2)) && (row_c >= ROW_W'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (advance) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

endmodule

// ===== src/mg3_line_store.sv =====
// two row buffers with one write and one registered read per cycle
module mg3_line_store import mg3_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  pixel_type        wr_upper,
   input  pixel_type        wr_middle,
   output pixel_type        rd_upper,
   output pixel_type        rd_middle
);

   pixel_type upper_mem [LINE_DEPTH];
   pixel_type middle_mem [LINE_DEPTH];
   pixel_type rd_upper_ff, rd_middle_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         rd_upper_ff  <= upper_mem[rd_addr];
         rd_middle_ff <= middle_mem[rd_addr];
      end
   end

   assign rd_upper  = rd_upper_ff;
   assign rd_middle = rd_middle_ff;

endmodule

// ===== src/mg3_window.sv =====
// 3x3 window columns and max-minus-min tree
module mg3_window import mg3_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  pixel_type top,
   input  pixel_type mid,
   input  pixel_type pix,
   output pixel_type gradient
);

   pixel_type win_ff [6];
   pixel_type v [9];
   pixel_type hi_a [4], lo_a [4], hi_b [2], lo_b [2], hi_c, lo_c, hi, lo;

   always_comb begin
      for (int k = 0; k < 6; k++) v[k] = win_ff[k];
      v[6] = top;
      v[7] = mid;
      v[8] = pix;

      for (int k = 0; k < 4; k++) begin
         hi_a[k] = pix_max(v[2*k], v[2*k+1]);
         lo_a[k] = pix_min(v[2*k], v[2*k+1]);
      end
      for (int k = 0; k < 2; k++) begin
         hi_b[k] = pix_max(hi_a[2*k], hi_a[2*k+1]);
         lo_b[k] = pix_min(lo_a[2*k], lo_a[2*k+1]);
      end
      hi_c = pix_max(hi_b[0], hi_b[1]);
      lo_c = pix_min(lo_b[0], lo_b[1]);
      hi   = pix_max(hi_c, v[8]);
      lo   = pix_min(lo_c, v[8]);
      gradient = hi - lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) win_ff[k] <= '0;
      end else if (shift) begin
         for (int k = 0; k < 3; k++) win_ff[k] <= win_ff[k+3];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= pix;
      end
   end

endmodule

// ===== src/morphological_gradient_3x3.sv =====
// top level of the streaming 3x3 morphological gradient
//
// Grayscale pixels come in on the req_ stream in raster order, one beat per
// pixel, with req_tuser marking the first pixel of a frame. For every pixel
// that completes a 3x3 window around an interior pixel, one beat leaves on the
// rsp_ stream carrying the window maximum minus minimum and the centre column
// and row; rsp_tlast flags the final result of the frame. Border pixels give
// no beat. It takes one pixel per clock cycle unless rsp_ stalls. A pixel
// passes stage 1 with the registered read of both line stores at its column,
// then the min/max tree into the result register. The user is to set image
// width and height through the csr_ port only while the block is idle; the
// block does not enforce it. Values outside the usable range are clamped
// (width 3..256, height at least 3). A line store entry is always written
// before it is read within a frame unless the width is changed mid-frame.
module morphological_gradient_3x3 import mg3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // pixel input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel
   input  logic                  req_tuser,   // start_of_frame
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] gradient, [15:8] centre_col,
                                              // [25:16] centre_row, rest zero
   output logic                  rsp_tlast    // frame_last
);

   // configuration registers
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;

   // stage 1: pixel waiting for its line store data
   logic       s1_valid_ff;
   pixel_type  s1_pix_ff;
   pos_type    s1_pos_ff;
   logic       hit_ff;        // previous beat wrote the column this one read
   pixel_type  byp_top_ff;
   pixel_type  byp_mid_ff;

   // result register
   logic              rsp_valid_ff;
   pixel_type         rsp_grad_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic              rsp_last_ff;

   pos_type   pos;
   logic      req_accept;
   logic      out_free;
   logic      s1_move;
   pixel_type rd_upper, rd_middle;
   pixel_type top_eff, mid_eff;
   pixel_type gradient;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow: stage 1 moves on unless its result is blocked
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && (!s1_pos_ff.interior || out_free);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   mg3_position u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_accept),
      .sof          (req_tuser),
      .image_width  (width_ff),
      .image_height (height_ff),
      .pos          (pos)
   );

   // line store read happens on accept, write when stage 1 moves on
   mg3_line_store u_line_store (
      .clock     (clock),
      .rd_en     (req_accept),
      .rd_addr   (pos.col),
      .wr_en     (s1_move),
      .wr_addr   (s1_pos_ff.col),
      .wr_upper  (mid_eff),
      .wr_middle (s1_pix_ff),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle)
   );

   // forward the write that raced with this beat's read
   assign top_eff = hit_ff ? byp_top_ff : rd_upper;
   assign mid_eff = hit_ff ? byp_mid_ff : rd_middle;

   mg3_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift    (s1_move),
      .top      (top_eff),
      .mid      (mid_eff),
      .pix      (s1_pix_ff),
      .gradient (gradient)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move && s1_pos_ff.interior) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff  <= req_tdata;
         s1_pos_ff  <= pos;
         hit_ff     <= s1_move && (pos.col == s1_pos_ff.col);
         byp_top_ff <= mid_eff;
         byp_mid_ff <= s1_pix_ff;
      end
      if (s1_move && s1_pos_ff.interior) begin
         rsp_grad_ff <= gradient;
         rsp_col_ff  <= s1_pos_ff.col - 1'b1;
         rsp_row_ff  <= s1_pos_ff.row - 1'b1;
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PIX_W - COL_W - ROW_W)'(0),
                        rsp_row_ff, rsp_col_ff, rsp_grad_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== bench/gradient_checker.sv =====
// checker for the 3x3 morphological gradient: tracks the window, predicts and compares beats
module gradient_checker import mg3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   output int                    mismatch_count,
   output int                    results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      pixel_type        grad;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
   } gradient_beat_type;

   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   pixel_type               upper_row [LINE_DEPTH];
   pixel_type               middle_row [LINE_DEPTH];
   pixel_type               window_px [6];
   int unsigned             col_pos;
   int unsigned             row_pos;
   gradient_beat_type       expected_gradients [$];

   // advance the window by one pixel and queue the gradient it completes, if any
   task automatic predict_gradient(input pixel_type pix, input logic sof);
      int unsigned       w;
      int unsigned       h;
      int unsigned       col;
      int unsigned       row;
      pixel_type         win [9];
      pixel_type         lo;
      pixel_type         hi;
      gradient_beat_type beat;
      w = width_reg;
      if (w < WIDTH_MIN) w = WIDTH_MIN;
      if (w > WIDTH_MAX) w = WIDTH_MAX;
      h = height_reg;
      if (h < HEIGHT_MIN) h = HEIGHT_MIN;
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = row_pos + 1;
      end
      if (row_pos >= h) row_pos = 0;
      col = col_pos;
      row = row_pos;
      for (int k = 0; k < 6; k++) win[k] = window_px[k];
      win[6] = upper_row[col];
      win[7] = middle_row[col];
      win[8] = pix;
      if (col >= 2 && row >= 2) begin
         lo = win[0];
         hi = win[0];
         for (int k = 1; k < 9; k++) begin
            if (win[k] < lo) lo = win[k];
            if (win[k] > hi) hi = win[k];
         end
         beat.grad = hi - lo;
         beat.col  = COL_W'(col - 1);
         beat.row  = ROW_W'(row - 1);
         beat.last = (col == w - 1) && (row == h - 1);
         expected_gradients.push_back(beat);
      end
      for (int k = 0; k < 6; k++) window_px[k] = win[k + 3];
      upper_row[col]  = win[7];
      middle_row[col] = pix;
      if (col + 1 >= w) begin
         col_pos = 0;
         row_pos = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_gradient();
      gradient_beat_type beat;
      if (expected_gradients.size() == 0) begin
         $display("%0t: unexpected result beat, expected none, got tdata %h tlast %b",
                  $time, rsp_tdata, rsp_tlast);
         mismatch_count++;
      end else begin
         beat = expected_gradients.pop_front();
         compare_field("gradient", beat.grad, rsp_tdata[7:0]);
         compare_field("centre_col", beat.col, rsp_tdata[15:8]);
         compare_field("centre_row", beat.row, rsp_tdata[25:16]);
         compare_field("frame_last", beat.last, rsp_tlast);
         compare_field("tdata padding", 0, rsp_tdata[RSP_DATA_W-1:26]);
      end
   endtask

   initial begin
      mismatch_count      = 0;
      results_outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         for (int k = 0; k < 6; k++) window_px[k] = '0;
         for (int k = 0; k < LINE_DEPTH; k++) begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
         end
         col_pos = 0;
         row_pos = 0;
         expected_gradients.delete();
      end else begin
         // a result in this cycle always belongs to an older pixel
         if (rsp_tvalid && rsp_tready) check_gradient();
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_data[WIDTH_REG_W-1:0];
            else height_reg = csr_data[HEIGHT_REG_W-1:0];
         end
         if (req_tvalid && req_tready) predict_gradient(req_tdata, req_tuser);
      end
      results_outstanding = expected_gradients.size();
   end

endmodule

// ===== bench/morphological_gradient_3x3_test.sv =====
// stimulus and verdict for the streaming 3x3 morphological gradient
module morphological_gradient_3x3_test import mg3_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1900;  // random pixels to send
   localparam int CALM_ITEMS  = 200;   // closing stretch with no idling on either side
   localparam int QUIET_LIMIT = 2000;  // cycles without any beat before giving up

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;   // [7:0] pixel
   logic                  req_tuser;   // start_of_frame
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [7:0] gradient, [15:8] centre_col,
                                       // [25:16] centre_row, rest zero
   logic                  rsp_tlast;   // frame_last

   int          mismatch_count;
   int          results_outstanding;
   int          items_sent;
   int          quiet_cycles;
   int unsigned width_now;   // clamped width the block is running with
   bit          calm;        // set for the closing stretch: no gaps, no stalls

   morphological_gradient_3x3 u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   gradient_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tlast           (rsp_tlast),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // width the block will use for a value written to the width register
   function automatic int unsigned usable_width(input logic [CSR_DATA_W-1:0] value);
      int unsigned w;
      w = value[WIDTH_REG_W-1:0];
      if (w < WIDTH_MIN) w = WIDTH_MIN;
      if (w > WIDTH_MAX) w = WIDTH_MAX;
      return w;
   endfunction

   // one pixel beat; returns once it has been taken
   task automatic send_pixel(input pixel_type pix, input logic sof);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = pix;
      req_tuser  = sof;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // stop sending, wait for every predicted gradient, then let border pixels
   // still in the two-stage pipeline drain out
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (results_outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // result side: ready held high in stretches, dropped in random bursts
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
   end

   // watchdog: any beat on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL morphological_gradient_3x3");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                    n;
      int                    gap_odds;
      int                    mode;
      int                    base;
      logic [CSR_DATA_W-1:0] wval;
      logic [CSR_DATA_W-1:0] hval;
      bit                    do_w;
      bit                    do_h;
      bit                    restart;
      bit                    sof;
      pixel_type             pix;

      reset        = 1'b1;
      csr_valid    = 1'b0;
      csr_index    = CSR_IMAGE_WIDTH;
      csr_data     = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      calm         = 1'b0;
      items_sent   = 0;
      quiet_cycles = 0;
      width_now    = WIDTH_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: smallest frame, one interior pixel, so every result is frame_last
      write_register(CSR_IMAGE_WIDTH, 10'd3);
      write_register(CSR_IMAGE_HEIGHT, 10'd3);
      width_now = 3;
      // checkerboard of the extremes: full-scale gradient
      for (int i = 0; i < 9; i++) send_pixel((i % 2 == 1) ? 8'hFF : 8'h00, i == 0);
      // flat frame following on without a start mark: position wraps, gradient zero
      for (int i = 0; i < 9; i++) send_pixel(8'h80, 1'b0);
      // start mark two pixels into a frame restarts the position
      for (int i = 0; i < 11; i++) send_pixel(pixel_type'($urandom), i == 2);

      // random phases, first few pinned to the register extremes
      for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
         settle();
         do_w    = 1'b1;
         do_h    = 1'b1;
         restart = 1'b0;
         n       = $urandom_range(30, 150);
         case (ph)
            0: begin
               wval = 10'd3;
               hval = 10'd1023;
               n    = 150;
            end
            1: begin
               // exactly one full-width frame so the widest centre column shows up
               wval    = 10'd256;
               hval    = 10'd3;
               n       = 3 * 256;
               restart = 1'b1;
            end
            2: begin
               wval = 10'd0;
               hval = 10'd0;
               n    = 60;
            end
            3: begin
               // width register keeps nine bits and then clamps to the store depth
               wval = 10'h3FF;
               hval = 10'd2;
               n    = 100;
            end
            default: begin
               do_w = $urandom_range(0, 3) != 0;
               do_h = $urandom_range(0, 3) != 0;
               case ($urandom_range(0, 19))
                  0, 1, 2:     wval = CSR_DATA_W'($urandom_range(0, 2));
                  3, 4:        wval = CSR_DATA_W'($urandom_range(200, 256));
                  5, 6, 7:     wval = CSR_DATA_W'($urandom_range(257, 1023));
                  default:     wval = CSR_DATA_W'($urandom_range(3, 20));
               endcase
               case ($urandom_range(0, 19))
                  0, 1, 2:     hval = CSR_DATA_W'($urandom_range(0, 2));
                  3, 4, 5, 6:  hval = CSR_DATA_W'($urandom_range(13, 1023));
                  default:     hval = CSR_DATA_W'($urandom_range(3, 12));
               endcase
            end
         endcase
         if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
         if (do_w) begin
            write_register(CSR_IMAGE_WIDTH, wval);
            // a wider row would read store columns this frame has not filled:
            // begin a new frame instead
            if (usable_width(wval) > width_now) restart = 1'b1;
            width_now = usable_width(wval);
         end
         if (do_h) write_register(CSR_IMAGE_HEIGHT, hval);

         gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
         mode     = $urandom_range(0, 2);
         base     = $urandom_range(0, 248);
         for (int i = 0; i < n; i++) begin
            if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
               hold_off($urandom_range(1, 15));
            end
            // narrow bands give small gradients, extremes give 0 or 255
            case (mode)
               0:       pix = pixel_type'($urandom);
               1:       pix = pixel_type'(base + $urandom_range(0, 7));
               default: pix = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            endcase
            sof = (i == 0 && restart) || ($urandom_range(0, 99) == 0);
            send_pixel(pix, sof);
            items_sent++;
            if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
         end
      end

      settle();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS morphological_gradient_3x3");
      end else begin
         $display("FAIL morphological_gradient_3x3");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/mg3_pkg.sv
src/mg3_position.sv
src/mg3_line_store.sv
src/mg3_window.sv
src/morphological_gradient_3x3.sv
bench/gradient_checker.sv
bench/morphological_gradient_3x3_test.sv
